>>> rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds, consequent holds the cycle after
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/gsp_pkg.sv
// Package with types and constants of the grid path solver
`default_nettype none
package gsp_pkg;
  localparam int MAX_SIDE  = 64;
  localparam int MAX_CELLS = 4096;
  localparam int SIDE_W    = 6;
  localparam int CELL_AW   = 12;
  localparam int CNT_W     = 13;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_SOLVE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_IDLE  = 2'd3;

  localparam logic [2:0] REG_SIDE      = 3'd0;
  localparam logic [2:0] REG_START_ROW = 3'd1;
  localparam logic [2:0] REG_START_COL = 3'd2;
  localparam logic [2:0] REG_END_ROW   = 3'd3;
  localparam logic [2:0] REG_END_COL   = 3'd4;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic        cell_open;
    logic [11:0] step_index;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [12:0] path_length;
    logic [12:0] searched_cells;
    logic [1:0]  step_dir;
    logic        step_valid;
  } out_t;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] dirs;
    logic [2:0] cnt;
    logic [2:0] nxt;
    logic       mz;
    logic [1:0] pdir;
  } stk_t;

  localparam int STK_W  = $bits(stk_t);
  localparam int CELL_W = 3;
endpackage
`default_nettype wire

>>> rtl/gsp_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none
module gsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/greedy_dfs_grid_path_solver.sv
// Top level of the depth-first grid path solver
// Write, read, idle commands: strobe in the cycle after start, one word per cycle.
// Solve: a clearing pass of the cell memory, then S_ENT_RD, S_ENT_WR, S_NB, S_SORT,
// S_DECIDE per cell entered and S_DECIDE, S_POP_LD per backtrack.
// Result strobe in the cycle busy falls; receiver cannot stall.
// Synchronous reset clears control and status (side to 64); memories keep contents.
`default_nettype none
module greedy_dfs_grid_path_solver (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire gsp_pkg::in_t  cmd,
  output logic               done,
  output gsp_pkg::out_t      result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [6:0]    cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_START = 4'd2, S_ENT_RD = 4'd3,
                         S_ENT_WR = 4'd4, S_NB = 4'd5, S_SORT = 4'd6, S_DECIDE = 4'd7,
                         S_POP_LD = 4'd8, S_DONE = 4'd9;

  logic [3:0] state;
  logic [6:0] grid_side;
  logic [5:0] start_row, start_col, end_row, end_col;
  logic [12:0] clr_cnt, top, path_len, searched;
  logic found_flag, rd_valid;
  logic [5:0] nr_r, nr_c, fr_row, fr_col;
  logic [7:0] fr_dirs;
  logic [2:0] fr_cnt, fr_next, nb;
  logic fr_mz;
  logic [3:0] cv;

  logic cell_we;
  logic [11:0] cell_waddr, cell_raddr;
  logic [2:0] cell_wdata, cell_rdata;
  logic stk_we;
  logic [11:0] stk_waddr, stk_raddr;
  gsp_pkg::stk_t stk_wdata, stk_rd;
  logic [gsp_pkg::STK_W-1:0] stk_rdata;

  logic accept;
  logic [6:0] side;
  logic [3:0] ing;
  logic [5:0] ngr [4];
  logic [5:0] ngc [4];
  logic [6:0] mdist [4];
  logic [1:0] rnk [4];
  logic [7:0] sort_dirs;
  logic [2:0] sort_cnt;
  logic push;
  logic [1:0] pick;
  logic [1:0] nb_cap;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign side = (grid_side > 7'(gsp_pkg::MAX_SIDE)) ? 7'(gsp_pkg::MAX_SIDE) : grid_side;
  assign stk_rd = gsp_pkg::stk_t'(stk_rdata);

  always_comb begin
    ngr[0] = fr_row - 6'd1; ngc[0] = fr_col;
    ngr[1] = fr_row;        ngc[1] = fr_col + 6'd1;
    ngr[2] = fr_row + 6'd1; ngc[2] = fr_col;
    ngr[3] = fr_row;        ngc[3] = fr_col - 6'd1;
    ing[0] = (fr_row != 6'd0);
    ing[1] = ({1'b0, fr_col} + 7'd1 < side);
    ing[2] = ({1'b0, fr_row} + 7'd1 < side);
    ing[3] = (fr_col != 6'd0);
    for (int i = 0; i < 4; i++) begin
      mdist[i] = {1'b0, (ngr[i] >= end_row) ? ngr[i] - end_row : end_row - ngr[i]}
               + {1'b0, (ngc[i] >= end_col) ? ngc[i] - end_col : end_col - ngc[i]};
    end
  end

  always_comb begin
    sort_dirs = '0;
    sort_cnt = 3'($countones(cv));
    for (int i = 0; i < 4; i++) begin
      rnk[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (j != i && cv[j] && (mdist[j] < mdist[i] || (mdist[j] == mdist[i] && j < i))) begin
          rnk[i] = rnk[i] + 2'd1;
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (cv[i]) begin
        sort_dirs[2*rnk[i] +: 2] = 2'(i);
      end
    end
  end

  assign push = (fr_next < fr_cnt) && (top < 13'(gsp_pkg::MAX_CELLS));
  assign pick = fr_dirs[2*fr_next[1:0] +: 2];
  assign nb_cap = 2'(nb - 3'd1);

  always_comb begin
    cell_we = 1'b0;
    cell_waddr = '0;
    cell_wdata = '0;
    cell_raddr = '0;
    stk_we = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = cmd.step_index;
    case (state)
      S_IDLE: begin
        if (accept && cmd.kind == gsp_pkg::KIND_WRITE) begin
          cell_we = 1'b1;
          cell_waddr = {cmd.cell_row, cmd.cell_col};
          cell_wdata = {cmd.cell_open, 2'b00};
        end
      end
      S_CLR: begin
        cell_raddr = clr_cnt[11:0];
        if (clr_cnt != 13'd0) begin
          cell_we = 1'b1;
          cell_waddr = 12'(clr_cnt - 13'd1);
          cell_wdata = {cell_rdata[2], 2'b00};
        end
      end
      S_ENT_RD: cell_raddr = {nr_r, nr_c};
      S_ENT_WR: begin
        cell_we = 1'b1;
        cell_waddr = {nr_r, nr_c};
        cell_wdata = {cell_rdata[2], 2'b11};
      end
      S_NB: cell_raddr = {ngr[nb[1:0]], ngc[nb[1:0]]};
      S_DECIDE: begin
        if (push) begin
          stk_we = 1'b1;
          stk_waddr = 12'(top - 13'd1);
          stk_wdata = '{row: fr_row, col: fr_col, dirs: fr_dirs, cnt: fr_cnt,
                        nxt: fr_next + 3'd1, mz: fr_mz, pdir: pick};
        end else begin
          cell_we = 1'b1;
          cell_waddr = {fr_row, fr_col};
          cell_wdata = {fr_mz, 2'b01};
          stk_raddr = 12'(top - 13'd2);
        end
      end
      default: ;
    endcase
  end

  gsp_ram #(.WIDTH(gsp_pkg::CELL_W), .DEPTH(gsp_pkg::MAX_CELLS)) u_cell (
    .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  gsp_ram #(.WIDTH(gsp_pkg::STK_W), .DEPTH(gsp_pkg::MAX_CELLS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      grid_side <= 7'(gsp_pkg::MAX_SIDE);
      start_row <= '0;
      start_col <= '0;
      end_row <= '0;
      end_col <= '0;
      found_flag <= 1'b0;
      path_len <= '0;
      searched <= '0;
      top <= '0;
      done <= 1'b0;
      rd_valid <= 1'b0;
      clr_cnt <= '0;
      nb <= '0;
    end else begin
      done <= 1'b0;
      rd_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gsp_pkg::REG_SIDE:      grid_side <= cfg_data;
          gsp_pkg::REG_START_ROW: start_row <= cfg_data[5:0];
          gsp_pkg::REG_START_COL: start_col <= cfg_data[5:0];
          gsp_pkg::REG_END_ROW:   end_row <= cfg_data[5:0];
          gsp_pkg::REG_END_COL:   end_col <= cfg_data[5:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.kind == gsp_pkg::KIND_SOLVE) begin
              state <= S_CLR;
              clr_cnt <= '0;
              found_flag <= 1'b0;
              path_len <= '0;
              searched <= '0;
              top <= '0;
            end else begin
              done <= 1'b1;
              rd_valid <= (cmd.kind == gsp_pkg::KIND_READ) && found_flag &&
                          (path_len != 13'd0) && ({1'b0, cmd.step_index} < path_len - 13'd1);
            end
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 13'd1;
          if (clr_cnt == 13'(gsp_pkg::MAX_CELLS)) begin
            state <= S_START;
          end
        end
        S_START: begin
          if ({1'b0, start_row} >= side || {1'b0, start_col} >= side) begin
            state <= S_DONE;
          end else begin
            nr_r <= start_row;
            nr_c <= start_col;
            state <= S_ENT_RD;
          end
        end
        S_ENT_RD: state <= S_ENT_WR;
        S_ENT_WR: begin
          searched <= searched + {12'd0, ~cell_rdata[0]};
          top <= top + 13'd1;
          fr_row <= nr_r;
          fr_col <= nr_c;
          fr_mz <= cell_rdata[2];
          if (nr_r == end_row && nr_c == end_col) begin
            found_flag <= 1'b1;
            path_len <= top + 13'd1;
            state <= S_DONE;
          end else begin
            nb <= '0;
            state <= S_NB;
          end
        end
        S_NB: begin
          if (nb != 3'd0) begin
            cv[nb_cap] <= ing[nb_cap] & cell_rdata[2] & ~cell_rdata[1];
          end
          nb <= nb + 3'd1;
          if (nb == 3'd4) begin
            state <= S_SORT;
          end
        end
        S_SORT: begin
          fr_dirs <= sort_dirs;
          fr_cnt <= sort_cnt;
          fr_next <= '0;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (push) begin
            nr_r <= ngr[pick];
            nr_c <= ngc[pick];
            state <= S_ENT_RD;
          end else begin
            top <= top - 13'd1;
            state <= (top == 13'd1) ? S_DONE : S_POP_LD;
          end
        end
        S_POP_LD: begin
          fr_row <= stk_rd.row;
          fr_col <= stk_rd.col;
          fr_dirs <= stk_rd.dirs;
          fr_cnt <= stk_rd.cnt;
          fr_next <= stk_rd.nxt;
          fr_mz <= stk_rd.mz;
          state <= S_DECIDE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    result.found = found_flag;
    result.path_length = path_len;
    result.searched_cells = searched;
    result.step_dir = rd_valid ? stk_rd.pdir : gsp_pkg::DIR_UP;
    result.step_valid = rd_valid;
  end
endmodule
`default_nettype wire

>>> rtl/gsp_checker.sv
// Port-level checker of the grid path solver and its bind
`default_nettype none
`include "assert_macros.svh"
module gsp_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire gsp_pkg::in_t  cmd,
  input wire logic          done,
  input wire gsp_pkg::out_t result,
  input wire logic          cfg_valid,
  input wire logic          cfg_ready,
  input wire logic [2:0]    cfg_index,
  input wire logic [6:0]    cfg_data
);
  `ASSERT_NEXT(a_item_word, clk, rst, start && !busy && cmd.kind != gsp_pkg::KIND_SOLVE, done)
  `ASSERT_IMPL(a_step_needs_found, clk, rst, done && result.step_valid, result.found)
  `ASSERT_IMPL(a_no_path_len, clk, rst, done && !result.found, result.path_length == 13'd0)
  `ASSERT_IMPL(a_len_le_seen, clk, rst, done, result.path_length <= result.searched_cells)
endmodule

bind greedy_dfs_grid_path_solver gsp_checker u_gsp_checker (.*);
`default_nettype wire

>>> sim/greedy_dfs_grid_path_solver_test.sv
// Testbench for the depth-first grid path solver: directed table, then random mazes
`timescale 1ns / 100ps
module greedy_dfs_grid_path_solver_test;

  typedef struct {
    bit             set_regs;
    int             side, srow, scol, erow, ecol;
    gsp_pkg::in_t   cmd;
    bit             typed;
    gsp_pkg::out_t  want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  gsp_pkg::in_t cmd = '0;
  logic cfg_valid = 0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic busy, done, cfg_ready;
  gsp_pkg::out_t result;

  greedy_dfs_grid_path_solver dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // solver mirror
  int side_reg, srow_reg, scol_reg, erow_reg, ecol_reg;
  bit maze[gsp_pkg::MAX_CELLS];
  bit on_path[gsp_pkg::MAX_CELLS];
  bit entered[gsp_pkg::MAX_CELLS];
  int fr_row[gsp_pkg::MAX_CELLS], fr_col[gsp_pkg::MAX_CELLS];
  int fr_cnt[gsp_pkg::MAX_CELLS], fr_next[gsp_pkg::MAX_CELLS];
  logic [1:0] fr_dirs[gsp_pkg::MAX_CELLS][4];
  logic [1:0] path_dirs[gsp_pkg::MAX_CELLS];
  int depth, path_len, searched;
  bit goal_hit;

  gsp_pkg::out_t pending_words[$];
  int errors = 0;
  int idle_pct = 0;

  function automatic int side_used();
    return side_reg > gsp_pkg::MAX_SIDE ? gsp_pkg::MAX_SIDE : side_reg;
  endfunction

  function automatic void rank_moves(int f);
    int dr[4] = '{-1, 0, 1, 0};
    int dc[4] = '{0, 1, 0, -1};
    int mdist[4];
    int n, j, nr, nc, d;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      nr = fr_row[f] + dr[i];
      nc = fr_col[f] + dc[i];
      if (nr < 0 || nc < 0 || nr >= side_used() || nc >= side_used()) continue;
      if (!maze[nr * gsp_pkg::MAX_SIDE + nc] || on_path[nr * gsp_pkg::MAX_SIDE + nc]) continue;
      d = (nr > erow_reg ? nr - erow_reg : erow_reg - nr) +
          (nc > ecol_reg ? nc - ecol_reg : ecol_reg - nc);
      j = n;
      while (j > 0 && mdist[j-1] > d) begin
        mdist[j] = mdist[j-1];
        fr_dirs[f][j] = fr_dirs[f][j-1];
        j--;
      end
      mdist[j] = d;
      fr_dirs[f][j] = i[1:0];
      n++;
    end
    fr_cnt[f] = n;
    fr_next[f] = 0;
  endfunction

  function automatic bit step_into(int r, int c);
    int f;
    f = depth;
    fr_row[f] = r;
    fr_col[f] = c;
    on_path[r * gsp_pkg::MAX_SIDE + c] = 1;
    if (!entered[r * gsp_pkg::MAX_SIDE + c]) begin
      entered[r * gsp_pkg::MAX_SIDE + c] = 1;
      searched++;
    end
    depth++;
    if (r == erow_reg && c == ecol_reg) return 1;
    rank_moves(f);
    return 0;
  endfunction

  function automatic void search_maze();
    int dr[4] = '{-1, 0, 1, 0};
    int dc[4] = '{0, 1, 0, -1};
    int f;
    logic [1:0] d;
    for (int i = 0; i < gsp_pkg::MAX_CELLS; i++) begin
      on_path[i] = 0;
      entered[i] = 0;
    end
    goal_hit = 0;
    searched = 0;
    path_len = 0;
    depth = 0;
    if (srow_reg >= side_used() || scol_reg >= side_used()) return;
    if (step_into(srow_reg, scol_reg)) begin
      goal_hit = 1;
      path_len = depth;
      return;
    end
    while (depth > 0) begin
      f = depth - 1;
      if (fr_next[f] < fr_cnt[f] && depth < gsp_pkg::MAX_CELLS) begin
        d = fr_dirs[f][fr_next[f]];
        fr_next[f]++;
        path_dirs[f] = d;
        if (step_into(fr_row[f] + dr[d], fr_col[f] + dc[d])) begin
          goal_hit = 1;
          path_len = depth;
          return;
        end
      end else begin
        on_path[fr_row[f] * gsp_pkg::MAX_SIDE + fr_col[f]] = 0;
        depth--;
      end
    end
  endfunction

  function automatic gsp_pkg::out_t solver_word(gsp_pkg::in_t c);
    gsp_pkg::out_t w;
    w = '0;
    case (c.kind)
      gsp_pkg::KIND_WRITE: maze[c.cell_row * gsp_pkg::MAX_SIDE + c.cell_col] = c.cell_open;
      gsp_pkg::KIND_SOLVE: search_maze();
      gsp_pkg::KIND_READ: begin
        if (goal_hit && path_len >= 1 && c.step_index < path_len - 1) begin
          w.step_valid = 1;
          w.step_dir = path_dirs[c.step_index];
        end
      end
      default: ;
    endcase
    w.found = goal_hit;
    w.path_length = path_len[12:0];
    w.searched_cells = searched[12:0];
    return w;
  endfunction

  task automatic report(string what, gsp_pkg::out_t got, gsp_pkg::out_t want);
    $display("mismatch %s: got %p want %p", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", result, '0);
      end else begin
        gsp_pkg::out_t w;
        w = pending_words.pop_front();
        if (result.found !== w.found) report("found", result, w);
        if (result.path_length !== w.path_length) report("path_length", result, w);
        if (result.searched_cells !== w.searched_cells) report("searched_cells", result, w);
        if (result.step_dir !== w.step_dir) report("step_dir", result, w);
        if (result.step_valid !== w.step_valid) report("step_valid", result, w);
      end
    end
  end

  task automatic drain();
    start <= 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[6:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      gsp_pkg::REG_SIDE:      side_reg = val & 7'h7f;
      gsp_pkg::REG_START_ROW: srow_reg = val & 6'h3f;
      gsp_pkg::REG_START_COL: scol_reg = val & 6'h3f;
      gsp_pkg::REG_END_ROW:   erow_reg = val & 6'h3f;
      default:                ecol_reg = val & 6'h3f;
    endcase
  endtask

  task automatic set_regs(int side, int sr, int sc, int er, int ec);
    drain();
    write_reg(gsp_pkg::REG_SIDE, side);
    write_reg(gsp_pkg::REG_START_ROW, sr);
    write_reg(gsp_pkg::REG_START_COL, sc);
    write_reg(gsp_pkg::REG_END_ROW, er);
    write_reg(gsp_pkg::REG_END_COL, ec);
  endtask

  task automatic send(gsp_pkg::in_t c, bit typed = 0, gsp_pkg::out_t want = '0);
    int gap;
    gsp_pkg::out_t w;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    w = solver_word(c);
    pending_words.insert(pending_words.size(), typed ? want : w);
  endtask

  function automatic gsp_pkg::in_t make_cmd(logic [1:0] k, int r, int c, bit op, int s);
    gsp_pkg::in_t x;
    x.kind = k;
    x.cell_row = r[5:0];
    x.cell_col = c[5:0];
    x.cell_open = op;
    x.step_index = s[11:0];
    return x;
  endfunction

  function automatic gsp_pkg::out_t make_word(bit f, int len, int cnt);
    gsp_pkg::out_t w;
    w = '0;
    w.found = f;
    w.path_length = len[12:0];
    w.searched_cells = cnt[12:0];
    return w;
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    int items, side, mode;
    side_reg = 64;
    srow_reg = 0; scol_reg = 0; erow_reg = 0; ecol_reg = 0;
    goal_hit = 0; path_len = 0; searched = 0; depth = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    r = '{default: 0};
    r.cmd = make_cmd(gsp_pkg::KIND_READ, 0, 0, 0, 0);
    r.typed = 1; r.want = make_word(0, 0, 0); rows.insert(rows.size(), r);
    r.cmd = make_cmd(gsp_pkg::KIND_IDLE, 63, 63, 1, 4095); rows.insert(rows.size(), r);
    r.cmd = make_cmd(gsp_pkg::KIND_WRITE, 63, 63, 1, 4095); rows.insert(rows.size(), r);
    r = '{default: 0};
    r.set_regs = 1; r.side = 64; r.srow = 63; r.scol = 63; r.erow = 63; r.ecol = 63;
    r.cmd = make_cmd(gsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
    r.typed = 1; r.want = make_word(1, 1, 1); rows.insert(rows.size(), r);
    r = '{default: 0};
    r.cmd = make_cmd(gsp_pkg::KIND_READ, 0, 0, 0, 0);
    r.typed = 1; r.want = make_word(1, 1, 1); rows.insert(rows.size(), r);
    r = '{default: 0};
    r.set_regs = 1; r.side = 127; r.srow = 63; r.scol = 63; r.erow = 63; r.ecol = 63;
    r.cmd = make_cmd(gsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
    r.typed = 1; r.want = make_word(1, 1, 1); rows.insert(rows.size(), r);
    r = '{default: 0};
    r.set_regs = 1; r.side = 3; r.srow = 5; r.scol = 0; r.erow = 0; r.ecol = 0;
    r.cmd = make_cmd(gsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
    r.typed = 1; r.want = make_word(0, 0, 0); rows.insert(rows.size(), r);
    r = '{default: 0};
    r.set_regs = 1; r.side = 0; r.srow = 0; r.scol = 0; r.erow = 0; r.ecol = 0;
    r.cmd = make_cmd(gsp_pkg::KIND_SOLVE, 0, 0, 0, 0);
    r.typed = 1; r.want = make_word(0, 0, 0); rows.insert(rows.size(), r);
    r = '{default: 0};
    for (int i = 0; i < 9; i++) begin
      r.cmd = make_cmd(gsp_pkg::KIND_WRITE, i / 3, i % 3, i != 4, 0);
      rows.insert(rows.size(), r);
    end
    r.set_regs = 1; r.side = 3; r.srow = 0; r.scol = 0; r.erow = 2; r.ecol = 2;
    r.cmd = make_cmd(gsp_pkg::KIND_SOLVE, 0, 0, 0, 0); rows.insert(rows.size(), r);
    r = '{default: 0};
    for (int i = 0; i < 5; i++) begin
      r.cmd = make_cmd(gsp_pkg::KIND_READ, 0, 0, 0, i); rows.insert(rows.size(), r);
    end
    r.set_regs = 1; r.side = 3; r.srow = 1; r.scol = 1; r.erow = 40; r.ecol = 63;
    r.cmd = make_cmd(gsp_pkg::KIND_SOLVE, 0, 0, 0, 0); rows.insert(rows.size(), r);
    r = '{default: 0};
    r.cmd = make_cmd(gsp_pkg::KIND_READ, 0, 0, 0, 4095); rows.insert(rows.size(), r);

    foreach (rows[i]) begin
      if (rows[i].set_regs)
        set_regs(rows[i].side, rows[i].srow, rows[i].scol, rows[i].erow, rows[i].ecol);
      send(rows[i].cmd, rows[i].typed, rows[i].want);
    end

    for (int i = 0; i < 16; i++) send(make_cmd(gsp_pkg::KIND_WRITE, i / 4, i % 4, 1, 0));

    items = 0;
    mode = 0;
    while (items < 1300) begin
      case (mode % 4)
        0: idle_pct = 0;
        1: idle_pct = 81;
        2: idle_pct = 33;
        default: idle_pct = $urandom_range(0, 50);
      endcase
      if ((mode % 16) == 5) side = 4;
      else side = $urandom_range(1, 3);
      mode++;
      if ($urandom_range(9) == 0)
        set_regs(side, $urandom_range(0, side), $urandom_range(0, side), 63, 63);
      else
        set_regs(side, $urandom_range(0, side - 1), $urandom_range(0, side - 1),
                 $urandom_range(0, side), $urandom_range(0, side - 1));
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(9) == 0)
          send(make_cmd(gsp_pkg::KIND_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 1), $urandom));
        else
          send(make_cmd(gsp_pkg::KIND_WRITE, $urandom_range(0, 3), $urandom_range(0, 3),
                        $urandom_range(0, 9) < 7, $urandom));
        items++;
      end
      if ($urandom_range(4) == 0) begin
        send(make_cmd(gsp_pkg::KIND_IDLE, $urandom, $urandom, $urandom, $urandom));
        items++;
      end
      send(make_cmd(gsp_pkg::KIND_SOLVE, $urandom, $urandom, $urandom, $urandom));
      items++;
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(4) == 0)
          send(make_cmd(gsp_pkg::KIND_READ, $urandom, $urandom, $urandom,
                        $urandom_range(0, 4095)));
        else
          send(make_cmd(gsp_pkg::KIND_READ, $urandom, $urandom, $urandom,
                        $urandom_range(0, 17)));
        items++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("PASS greedy_dfs_grid_path_solver");
    end else begin
      $display("FAIL greedy_dfs_grid_path_solver");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("FAIL greedy_dfs_grid_path_solver");
    $finish;
  end
endmodule
